### hdl/adv_data_uuid128_filter_top_assert.svh
// Assertion helpers shared by the filter modules. They expect signals named
// clk and arst_n in the module that uses them.
`ifndef ADV_DATA_UUID128_FILTER_TOP_ASSERT_SVH
`define ADV_DATA_UUID128_FILTER_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define AUVF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define AUVF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/auvf_pkg.sv
`default_nettype none
package auvf_pkg;

	localparam int unsigned ENTRY_BYTES = 16;
	localparam int unsigned IDX_W       = $clog2(ENTRY_BYTES);
	localparam int unsigned TARGET_W    = ENTRY_BYTES * 8;

	localparam logic [7:0] AD_TYPE_UUID128_SOME = 8'h06;
	localparam logic [7:0] AD_TYPE_UUID128_ALL  = 8'h07;

	// Parser phase codes.
	localparam logic [2:0] PH_LEN  = 3'd0;
	localparam logic [2:0] PH_TYPE = 3'd1;
	localparam logic [2:0] PH_UUID = 3'd2;
	localparam logic [2:0] PH_SKIP = 3'd3;
	localparam logic [2:0] PH_STOP = 3'd4;

	// End status codes.
	localparam logic [1:0] END_CLEAN     = 2'd0;
	localparam logic [1:0] END_ZERO_LEN  = 2'd1;
	localparam logic [1:0] END_TRUNCATED = 2'd2;

	// Configuration register indexes.
	localparam logic REG_TARGET_LOW  = 1'b0;
	localparam logic REG_TARGET_HIGH = 1'b1;

	typedef struct packed {
		logic [7:0] ad_byte;
		logic       last_byte;
	} auvf_item_t;

	typedef struct packed {
		logic       found;
		logic [1:0] end_status;
	} auvf_result_t;

endpackage
`default_nettype wire

### hdl/auvf_in_if.sv
`default_nettype none
interface auvf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ad_byte;
	logic       last_byte;

	modport source (output valid, output ad_byte, output last_byte, input ready);
	modport sink (input valid, input ad_byte, input last_byte, output ready);
endinterface
`default_nettype wire

### hdl/auvf_out_if.sv
`default_nettype none
interface auvf_out_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic [1:0] end_status;

	modport source (output valid, output found, output end_status, input ready);
	modport sink (input valid, input found, input end_status, output ready);
endinterface
`default_nettype wire

### hdl/auvf_cfg_if.sv
`default_nettype none
interface auvf_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [63:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hdl/auvf_cfg_regs.sv
`default_nettype none
module auvf_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	auvf_cfg_if.sink                           cfg,
	output logic [auvf_pkg::TARGET_W-1:0]      target
);
	import auvf_pkg::*;

	logic [63:0] target_low_q;
	logic [63:0] target_high_q;

	assign cfg.ready = 1'b1;
	assign target    = {target_high_q, target_low_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_low_q  <= '0;
			target_high_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_TARGET_LOW:  target_low_q  <= cfg.data;
				REG_TARGET_HIGH: target_high_q <= cfg.data;
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

### hdl/auvf_parser.sv
`default_nettype none
module auvf_parser (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire auvf_pkg::auvf_item_t         item,
	input  wire logic [auvf_pkg::TARGET_W-1:0] target,
	output auvf_pkg::auvf_result_t            result
);
	import auvf_pkg::*;

	logic [2:0]       phase_q, phase_d;
	logic [7:0]       left_q, left_d, left_dec;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             eq_q, eq_d, eq_now;
	logic             match_q, match_d;
	logic [7:0]       tbyte;
	logic [7:0]       b;

	assign b        = item.ad_byte;
	assign left_dec = left_q - 8'd1;
	assign tbyte    = target[{idx_q, 3'b000} +: 8];
	assign eq_now   = eq_q && (b == tbyte);

	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		idx_d   = idx_q;
		eq_d    = eq_q;
		match_d = match_q;
		case (phase_q)
			PH_LEN: begin
				if (b == 8'd0) begin
					phase_d = PH_STOP;
				end else begin
					left_d  = b;
					phase_d = PH_TYPE;
				end
			end
			PH_TYPE: begin
				left_d = left_dec;
				idx_d  = '0;
				eq_d   = 1'b1;
				if (b == AD_TYPE_UUID128_SOME || b == AD_TYPE_UUID128_ALL) begin
					phase_d = PH_UUID;
				end else begin
					phase_d = PH_SKIP;
				end
				if (left_dec == 8'd0) begin
					phase_d = PH_LEN;
				end
			end
			PH_UUID: begin
				if (idx_q == IDX_W'(ENTRY_BYTES - 1)) begin
					if (eq_now) begin
						match_d = 1'b1;
					end
					idx_d = '0;
					eq_d  = 1'b1;
				end else begin
					idx_d = idx_q + IDX_W'(1);
					eq_d  = eq_now;
				end
				left_d = left_dec;
				if (left_dec == 8'd0) begin
					phase_d = PH_LEN;
				end
			end
			PH_SKIP: begin
				left_d = left_dec;
				if (left_dec == 8'd0) begin
					phase_d = PH_LEN;
				end
			end
			PH_STOP: ;
			default: phase_d = PH_STOP;
		endcase
	end

	always_comb begin
		result.found = match_d;
		if (phase_d == PH_STOP) begin
			result.end_status = END_ZERO_LEN;
		end else if (phase_d != PH_LEN) begin
			result.end_status = END_TRUNCATED;
		end else begin
			result.end_status = END_CLEAN;
		end
	end

	// The last byte of a record returns the parser to its idle state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN;
			left_q  <= '0;
			idx_q   <= '0;
			eq_q    <= 1'b1;
			match_q <= 1'b0;
		end else if (step) begin
			if (item.last_byte) begin
				phase_q <= PH_LEN;
				left_q  <= '0;
				idx_q   <= '0;
				eq_q    <= 1'b1;
				match_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				left_q  <= left_d;
				idx_q   <= idx_d;
				eq_q    <= eq_d;
				match_q <= match_d;
			end
		end
	end

`include "adv_data_uuid128_filter_top_assert.svh"

	`AUVF_ASSERT_SAME(a_field_count_live,
		(phase_q == PH_TYPE || phase_q == PH_UUID || phase_q == PH_SKIP),
		(left_q != 8'd0), "field byte count is zero inside a field")
	`AUVF_ASSERT_NEXT(a_match_holds, (step && !item.last_byte && match_q), match_q,
		"match latch dropped before the record ended")
	`AUVF_ASSERT_NEXT(a_last_clears, (step && item.last_byte),
		(phase_q == PH_LEN && !match_q), "parser not cleared after the last byte")
endmodule
`default_nettype wire

### hdl/adv_data_uuid128_filter_top.sv
`default_nettype none
// Advertising-data filter for 128-bit service UUIDs. One record byte is taken
// per request, with last_byte set on the final byte of the record; the block
// walks the length-type-value fields and compares each complete 16-byte entry
// of a type 0x06 or 0x07 field with the target loaded through the two
// configuration registers (low and high halves, first over-the-air byte in
// bits 7:0). One result per record leaves on the output channel after the
// last byte: found, and end_status 0 for a clean end, 1 for a zero length
// byte, 2 for a truncated field. Throughput is one byte per clock while no
// last byte is stalled; a byte is registered on entry and parsed from that
// register, and a result appears on the output in the cycle after its last
// byte is parsed. Only the last byte of a record waits on a full result
// register; other bytes keep flowing while a result is held.
module adv_data_uuid128_filter_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	auvf_in_if.sink    ad_in,
	auvf_out_if.source res_out,
	auvf_cfg_if.sink   cfg
);
	import auvf_pkg::*;

	logic [TARGET_W-1:0] target;
	logic                valid_s1;
	auvf_item_t          item_s1;
	logic                s1_go;
	auvf_result_t        parse_res;
	logic                res_valid_q;
	auvf_result_t        res_q;

	auvf_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.target (target)
	);

	assign s1_go = valid_s1 && (!item_s1.last_byte || !res_valid_q || res_out.ready);
	assign ad_in.ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ad_in.ready) begin
			valid_s1 <= ad_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ad_in.ready && ad_in.valid) begin
			item_s1.ad_byte   <= ad_in.ad_byte;
			item_s1.last_byte <= ad_in.last_byte;
		end
	end

	auvf_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (s1_go),
		.item   (item_s1),
		.target (target),
		.result (parse_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go && item_s1.last_byte) begin
			res_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && item_s1.last_byte) begin
			res_q <= parse_res;
		end
	end

	assign res_out.valid      = res_valid_q;
	assign res_out.found      = res_q.found;
	assign res_out.end_status = res_q.end_status;

`include "adv_data_uuid128_filter_top_assert.svh"

	`AUVF_ASSERT_NEXT(a_last_gives_result, (s1_go && item_s1.last_byte), res_valid_q,
		"no result after the last byte of a record")
	`AUVF_ASSERT_NEXT(a_stalled_last_held,
		(valid_s1 && item_s1.last_byte && res_valid_q && !res_out.ready),
		(valid_s1 && item_s1.last_byte), "stalled last byte was lost")
	`AUVF_ASSERT_SAME(a_plain_byte_flows, (valid_s1 && !item_s1.last_byte), s1_go,
		"a byte that ends no record was stalled")
endmodule
`default_nettype wire
